// File: design/ssbk_pkg.sv
package ssbk_pkg;

    // Table capacity and derived widths
    localparam int MAX_RECORDS = 16;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // Record field widths
    localparam int KEY_W   = 16;
    localparam int SCORE_W = 14;
    localparam int POS_W   = 4;
    localparam int REC_W   = KEY_W + SCORE_W + POS_W;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Command codes carried on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SORT = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } rec_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        rec_t             data;
    } store_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } store_rd_t;

endpackage

// File: design/ssbk_store.sv
module ssbk_store
    import ssbk_pkg::*;
(
    input  logic      clk,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output rec_t      rd_a,
    output rec_t      rd_b
);

    rec_t mem [MAX_RECORDS];
    rec_t rd_a_reg;
    rec_t rd_b_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read two entries, hold the data until the next read request
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a_reg <= mem[rd.addr_a];
            rd_b_reg <= mem[rd.addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// File: design/shell_sort_by_key_core.sv
// Channel  Dir  Fields (lowest bit up)                            Beat
// s_*      in   tuser: operation; tdata: roll_number, score, pad   load or sort command
// m_*      out  tdata: sorted_key, sorted_score, load_position,    one sorted record
//               pad; tlast: last
//
// Loads stream back to back. A sort reads each pair in ST_PASS and compares it in ST_CMP;
// a swap adds ST_SWAP for the second write (one write port on the record memory), and
// each pass ends in a further ST_PASS. Each record out is read in ST_EMIT_RD, sent in ST_EMIT.
// s_tready is low from the sort command until the last record is in the output register.
// A stalled output holds ST_EMIT; rst_n clears the count and control, not the table.
module shell_sort_by_key_core
    import ssbk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // roll_number[15:0], score[29:16], zero pad
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // sorted_key[15:0], sorted_score[29:16],
                                             // load_position[33:30], zero pad
    output logic                  m_tlast    // last
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PASS    = 3'd1;
    localparam logic [2:0] ST_CMP     = 3'd2;
    localparam logic [2:0] ST_SWAP    = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    localparam int SUM_W = CNT_W + 1;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] gap_reg, gap_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             swapped_reg, swapped_next;
    logic             out_valid_reg, out_valid_next;
    rec_t             out_rec_reg, out_rec_next;
    logic             out_last_reg, out_last_next;

    store_wr_t        wr;
    store_rd_t        rd;
    rec_t             rd_a;
    rec_t             rd_b;

    logic             in_beat;
    logic [SUM_W-1:0] pair_sum;
    logic             pair_in_range;
    logic [CNT_W-1:0] gap_half;
    logic             out_free;
    logic             emit_last;
    logic [POS_W-1:0] load_pos;

    ssbk_store u_store (
        .clk  (clk),
        .wr   (wr),
        .rd   (rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // Partner index and end-of-pass test
    assign pair_sum      = SUM_W'(idx_reg) + SUM_W'(gap_reg);
    assign pair_in_range = pair_sum < SUM_W'(n_reg);
    assign gap_half      = gap_reg >> 1;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit_last = (SUM_W'(idx_reg) + SUM_W'(1)) == SUM_W'(n_reg);
    assign load_pos  = POS_W'(count_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        gap_next       = gap_reg;
        idx_next       = idx_reg;
        swapped_next   = swapped_reg;
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;

        wr.en          = 1'b0;
        wr.addr        = idx_reg;
        wr.data        = rd_b;
        rd.en          = 1'b0;
        rd.addr_a      = idx_reg;
        rd.addr_b      = pair_sum[IDX_W-1:0];

        // Drop the output beat once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        if (count_reg < CNT_W'(MAX_RECORDS))
                        begin
                            wr.en         = 1'b1;
                            wr.addr       = count_reg[IDX_W-1:0];
                            wr.data.key   = s_tdata[KEY_W-1:0];
                            wr.data.score = s_tdata[KEY_W +: SCORE_W];
                            wr.data.pos   = load_pos;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        n_next       = count_reg;
                        gap_next     = count_reg >> 1;
                        idx_next     = '0;
                        swapped_next = 1'b0;
                        if ((count_reg >> 1) == '0)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_PASS;
                        end
                    end
                end
            end

            ST_PASS:
            begin
                if (pair_in_range)
                begin
                    rd.en      = 1'b1;
                    state_next = ST_CMP;
                end
                else if (swapped_reg)
                begin
                    // Repeat the pass at the same gap
                    idx_next     = '0;
                    swapped_next = 1'b0;
                end
                else
                begin
                    // Halve the gap, or finish after gap one
                    gap_next     = gap_half;
                    idx_next     = '0;
                    swapped_next = 1'b0;
                    if (gap_half == '0)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_CMP:
            begin
                if (rd_a.key > rd_b.key)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = idx_reg;
                    wr.data    = rd_b;
                    state_next = ST_SWAP;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_PASS;
                end
            end

            ST_SWAP:
            begin
                wr.en        = 1'b1;
                wr.addr      = pair_sum[IDX_W-1:0];
                wr.data      = rd_a;
                swapped_next = 1'b1;
                idx_next     = idx_reg + IDX_W'(1);
                state_next   = ST_PASS;
            end

            ST_EMIT_RD:
            begin
                rd.en      = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = rd_a;
                    out_last_next  = emit_last;
                    if (emit_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sort bookkeeping and output payload
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        gap_reg      <= gap_next;
        idx_reg      <= idx_next;
        swapped_reg  <= swapped_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - REC_W)'(0), out_rec_reg};
    assign m_tlast  = out_last_reg;

endmodule
